// ===== rtl/core/bgs_pkg.sv =====
// ----------------------------------------------------------------------------
// bgs_pkg
// shared sizes, item codes, queue entry type and the sigmoid lookup table
// ----------------------------------------------------------------------------
package bgs_pkg;

	localparam int NEURONS         = 64;
	localparam int SIGMOID_ENTRIES = 1024;

	// fixed field widths
	localparam int KIND_W  = 2;
	localparam int ROW_W   = 6;
	localparam int VALUE_W = 16;
	localparam int RAND_W  = 16;
	localparam int OUT_IDX_W = 6;

	// derived sizes
	localparam int IDX_W     = (NEURONS > 1) ? $clog2(NEURONS) : 1;
	localparam int WADDR_W   = $clog2(NEURONS * NEURONS);
	localparam int ACC_W     = VALUE_W + $clog2(NEURONS + 1);
	localparam int SIG_IDX_W = $clog2(SIGMOID_ENTRIES);
	localparam int POT_OFS_W = 12;
	localparam int PROD_W    = POT_OFS_W + $clog2(SIGMOID_ENTRIES + 1);
	localparam int SIG_W     = 16;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// item kinds on the input port
	localparam logic [KIND_W-1:0] KIND_WEIGHT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_BIAS   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd2;

	// exp(-1/256) in q0.32
	localparam logic [63:0] EXP_STEP_Q32 = 64'd4278222805;

	typedef enum logic [1:0] {
		OP_WEIGHT,
		OP_BIAS,
		OP_UPDATE
	} op_t;

	typedef struct packed {
		op_t                       op;
		logic [ROW_W-1:0]          row;
		logic [ROW_W-1:0]          column;
		logic signed [VALUE_W-1:0] value;
		logic                      initial_bit;
		logic [RAND_W-1:0]         random_value;
	} qent_t;

	typedef struct packed {
		logic  valid;
		qent_t ent;
	} push_t;

	typedef logic [SIG_W-1:0] sig_table_t [SIGMOID_ENTRIES];

	// exp(-a/256) in q0.32 by repeated squaring, each product rounded
	function automatic logic [63:0] exp_neg_q32(input logic [11:0] a);
		logic [63:0] pw;
		logic [63:0] e;
		int i;
		pw = EXP_STEP_Q32;
		e  = 64'd1 << 32;
		for (i = 0; i < 12; i++) begin
			if (a[i]) begin
				e = (e * pw + (64'd1 << 31)) >> 32;
			end
			pw = (pw * pw + (64'd1 << 31)) >> 32;
		end
		return e;
	endfunction

	// one table entry: rounded sigmoid in q0.16, long division by shift and subtract
	function automatic logic [SIG_W-1:0] sig_entry(input int k);
		int          m;
		int          i;
		logic [11:0] a;
		logic [63:0] e;
		logic [63:0] den;
		logic [63:0] num;
		logic [63:0] rem;
		logic [48:0] q;
		m   = -2048 + (k * 4096) / SIGMOID_ENTRIES;
		a   = 12'((m < 0) ? -m : m);
		e   = exp_neg_q32(a);
		den = (64'd1 << 32) + e;
		num = (m >= 0) ? (64'd1 << 48) : (e << 16);
		num = num + (den >> 1);
		rem = 64'd0;
		q   = 49'd0;
		for (i = 48; i >= 0; i--) begin
			rem = {rem[62:0], num[i]};
			if (rem >= den) begin
				rem  = rem - den;
				q[i] = 1'b1;
			end
		end
		return (q > 49'd65535) ? 16'hFFFF : q[15:0];
	endfunction

	function automatic sig_table_t build_sig_table();
		sig_table_t t;
		int k;
		for (k = 0; k < SIGMOID_ENTRIES; k++) begin
			t[k] = sig_entry(k);
		end
		return t;
	endfunction

	localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage

// ===== rtl/core/bgs_front.sv =====
// ----------------------------------------------------------------------------
// bgs_front
// input stage: takes items, drops unused kinds and out-of-range writes
// ----------------------------------------------------------------------------
module bgs_front import bgs_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [KIND_W-1:0]         kind,
	input  logic [ROW_W-1:0]          row,
	input  logic [ROW_W-1:0]          column,
	input  logic signed [VALUE_W-1:0] value,
	input  logic                      initial_bit,
	input  logic [RAND_W-1:0]         random_value,
	output push_t                     push,
	input  logic                      queue_full
);

	logic  valid_s1;
	qent_t ent_s1;
	logic  keep;
	op_t   op;
	logic  row_ok;
	logic  col_ok;

	assign row_ok = (32'(row) < NEURONS);
	assign col_ok = (32'(column) < NEURONS);

	always_comb begin
		keep = 1'b0;
		op   = OP_UPDATE;
		unique case (kind)
			KIND_WEIGHT: begin
				keep = row_ok && col_ok;
				op   = OP_WEIGHT;
			end
			KIND_BIAS: begin
				keep = row_ok;
				op   = OP_BIAS;
			end
			KIND_UPDATE: begin
				keep = 1'b1;
				op   = OP_UPDATE;
			end
			default: begin
				keep = 1'b0;
				op   = OP_UPDATE;
			end
		endcase
	end

	// held item waits here while the queue is full
	assign in_stall = valid_s1 && queue_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			ent_s1.op           <= op;
			ent_s1.row          <= row;
			ent_s1.column       <= column;
			ent_s1.value        <= value;
			ent_s1.initial_bit  <= initial_bit;
			ent_s1.random_value <= random_value;
		end
	end

	assign push.valid = valid_s1 && !queue_full;
	assign push.ent   = ent_s1;

endmodule

// ===== rtl/core/bgs_queue.sv =====
// ----------------------------------------------------------------------------
// bgs_queue
// short fifo between the input stage and the sampling engine
// ----------------------------------------------------------------------------
module bgs_queue import bgs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	output logic  full,
	output logic  head_valid,
	output qent_t head,
	input  logic  pop
);

	qent_t             entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_pop;

	assign full       = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entries_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push.valid && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push.valid && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			entries_q[wr_ptr_q] <= push.ent;
		end
	end

endmodule

// ===== rtl/core/bgs_back.sv =====
// ----------------------------------------------------------------------------
// bgs_back
// sampling engine: weight and bias stores, row accumulation, sigmoid lookup
// ----------------------------------------------------------------------------
module bgs_back import bgs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  qent_t                head,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [OUT_IDX_W-1:0] neuron_index,
	output logic                 new_bit,
	output logic                 sweep_end
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_DRAIN,
		ST_CLAMP,
		ST_LOOK,
		ST_DECIDE
	} state_t;

	state_t                    state_q;
	logic [NEURONS-1:0]        bits_q;
	logic [IDX_W-1:0]          next_neuron_q;
	logic [IDX_W-1:0]          j_q;
	logic [WADDR_W-1:0]        base_q;
	logic [RAND_W-1:0]         rnd_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic                      rd_valid_s1;
	logic                      bit_s1;
	logic [SIG_IDX_W-1:0]      idx_q;
	logic [SIG_W-1:0]          sig_q;
	logic signed [VALUE_W-1:0] w_q;
	logic signed [VALUE_W-1:0] bias_q;
	logic                      out_valid_q;
	logic [OUT_IDX_W-1:0]      neuron_index_q;
	logic                      new_bit_q;
	logic                      sweep_end_q;

	logic signed [VALUE_W-1:0] weight_mem [NEURONS*NEURONS];
	logic signed [VALUE_W-1:0] bias_mem [NEURONS];

	logic                      wgt_we;
	logic                      bias_we;
	logic [WADDR_W-1:0]        wgt_waddr;
	logic [WADDR_W-1:0]        wgt_raddr;
	logic [IDX_W-1:0]          head_row;
	logic [IDX_W-1:0]          head_col;
	logic                      out_free;
	logic                      last_j;
	logic signed [ACC_W-1:0]   pot;
	logic signed [ACC_W-1:0]   pot_c;
	logic [POT_OFS_W-1:0]      pot_ofs;
	logic [PROD_W-1:0]         prod;
	logic                      sample;

	localparam logic signed [ACC_W-1:0] POT_HI  = ACC_W'(2047);
	localparam logic signed [ACC_W-1:0] POT_LO  = -ACC_W'(2048);
	localparam logic signed [ACC_W-1:0] POT_OFS = ACC_W'(2048);

	assign pop      = (state_q == ST_IDLE) && head_valid;
	assign head_row = IDX_W'(head.row);
	assign head_col = IDX_W'(head.column);
	assign wgt_we   = pop && (head.op == OP_WEIGHT);
	assign bias_we  = pop && (head.op == OP_BIAS);
	assign wgt_waddr = WADDR_W'(head_row) * WADDR_W'(NEURONS) + WADDR_W'(head_col);
	assign wgt_raddr = base_q + WADDR_W'(j_q);
	assign out_free = !out_valid_q || !out_stall;
	assign last_j   = (j_q == IDX_W'(NEURONS - 1));

	// potential, clamp to [-8, 8) and table index
	always_comb begin
		pot = acc_q + ACC_W'(bias_q);
		if (pot > POT_HI) begin
			pot_c = POT_HI;
		end else if (pot < POT_LO) begin
			pot_c = POT_LO;
		end else begin
			pot_c = pot;
		end
		pot_ofs = POT_OFS_W'(pot_c + POT_OFS);
		prod    = PROD_W'(pot_ofs) * PROD_W'(SIGMOID_ENTRIES);
	end

	assign sample = (sig_q > rnd_q);

	// weight store, registered read
	always_ff @(posedge clk) begin
		if (wgt_we) begin
			weight_mem[wgt_waddr] <= head.value;
		end
		w_q <= weight_mem[wgt_raddr];
	end

	// bias store, read at the neuron due next
	always_ff @(posedge clk) begin
		if (bias_we) begin
			bias_mem[head_row] <= head.value;
		end
		bias_q <= bias_mem[next_neuron_q];
	end

	// sigmoid rom
	always_ff @(posedge clk) begin
		sig_q <= SIG_TABLE[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			bits_q         <= '0;
			next_neuron_q  <= '0;
			j_q            <= '0;
			base_q         <= '0;
			rnd_q          <= '0;
			acc_q          <= '0;
			rd_valid_s1    <= 1'b0;
			bit_s1         <= 1'b0;
			idx_q          <= '0;
			out_valid_q    <= 1'b0;
			neuron_index_q <= '0;
			new_bit_q      <= 1'b0;
			sweep_end_q    <= 1'b0;
		end else begin
			// in the decide state the result register is reloaded instead
			if (out_valid_q && !out_stall && (state_q != ST_DECIDE)) begin
				out_valid_q <= 1'b0;
			end

			// weight read pipe stage
			rd_valid_s1 <= (state_q == ST_ACC);
			bit_s1      <= bits_q[j_q];

			if (pop && (head.op == OP_UPDATE)) begin
				acc_q <= '0;
			end else if (rd_valid_s1 && bit_s1) begin
				acc_q <= acc_q + ACC_W'(w_q);
			end

			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						unique case (head.op)
							OP_BIAS: begin
								bits_q[head_row] <= head.initial_bit;
							end
							OP_UPDATE: begin
								base_q  <= WADDR_W'(next_neuron_q) * WADDR_W'(NEURONS);
								rnd_q   <= head.random_value;
								j_q     <= '0;
								state_q <= ST_ACC;
							end
							default: begin
							end
						endcase
					end
				end
				ST_ACC: begin
					if (last_j) begin
						state_q <= ST_DRAIN;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_CLAMP;
				end
				ST_CLAMP: begin
					idx_q   <= SIG_IDX_W'(prod >> POT_OFS_W);
					state_q <= ST_LOOK;
				end
				ST_LOOK: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (out_free) begin
						out_valid_q           <= 1'b1;
						neuron_index_q        <= OUT_IDX_W'(next_neuron_q);
						new_bit_q             <= sample;
						sweep_end_q           <= (next_neuron_q == IDX_W'(NEURONS - 1));
						bits_q[next_neuron_q] <= sample;
						next_neuron_q <= (next_neuron_q == IDX_W'(NEURONS - 1)) ?
							'0 : next_neuron_q + 1'b1;
						state_q               <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign neuron_index = neuron_index_q;
	assign new_bit      = new_bit_q;
	assign sweep_end    = sweep_end_q;

endmodule

// ===== rtl/core/boltzmann_gibbs_sweep.sv =====
// ----------------------------------------------------------------------------
// boltzmann_gibbs_sweep
// gibbs sampler for a binary boltzmann machine, one neuron per update item
// ----------------------------------------------------------------------------
//
//  channel  | handshake          | fields
//  ---------+--------------------+----------------------------------------------
//  in       | in_valid/in_stall  | kind row column value initial_bit random_value
//  out      | out_valid/out_stall| neuron_index new_bit sweep_end
//
//  weight and bias items are written as the engine pops them in the idle state
//  an update item keeps the engine busy while the single accumulator walks one
//  weight row through the weight memory port, then drain, clamp, look and decide
//  reset clears neuron bits, the neuron pointer and all handshake state;
//  weight and bias stores hold nothing until written
//  a stalled result waits in the output register while the input stage and
//  queue keep taking load items until the queue is full
//
module boltzmann_gibbs_sweep import bgs_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	// input channel
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [KIND_W-1:0]         kind,
	input  logic [ROW_W-1:0]          row,
	input  logic [ROW_W-1:0]          column,
	input  logic signed [VALUE_W-1:0] value,
	input  logic                      initial_bit,
	input  logic [RAND_W-1:0]         random_value,
	// output channel
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [OUT_IDX_W-1:0]      neuron_index,
	output logic                      new_bit,
	output logic                      sweep_end
);

	push_t push;
	logic  queue_full;
	logic  head_valid;
	qent_t head;
	logic  pop;

	// front: registers the item and drops kind 3 and out-of-range writes
	bgs_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.row          (row),
		.column       (column),
		.value        (value),
		.initial_bit  (initial_bit),
		.random_value (random_value),
		.push         (push),
		.queue_full   (queue_full)
	);

	// queue decouples item intake from the long update runs
	bgs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (queue_full),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	// back: stores, accumulation, sigmoid lookup and the result register
	bgs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.neuron_index (neuron_index),
		.new_bit      (new_bit),
		.sweep_end    (sweep_end)
	);

endmodule
